// ----- sv/obea_pkg.sv -----
// ----------------------------------------------------------------------------
// obea_pkg
// Shared types, field widths and codes of the octave band energy analyzer.
// ----------------------------------------------------------------------------
package obea_pkg;

  // Default sizes of the cascade and of the band accumulators
  localparam int DEF_OCTAVES   = 8;
  localparam int DEF_SUM_WIDTH = 48;

  // Field and datapath widths
  localparam int SAMPLE_W     = 16;
  localparam int LP_W         = 16;
  localparam int SLP_W        = 18;
  localparam int MAG_W        = 19;
  localparam int SHIFT_W      = 4;
  localparam int BAND_W       = 4;
  localparam int BAND_SUM_W   = 48;
  localparam int FRAME_W      = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;
  localparam int OCT_LIMIT_W  = 5;

  // Item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_SHIFT   = 1'b1;

  // Configuration reset values
  localparam logic [SHIFT_W-1:0] LOWPASS_SHIFT_RST = 4'd1;
  localparam logic [SHIFT_W-1:0] SPLIT_SHIFT_RST   = 4'd2;

  // Input item
  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [BAND_W-1:0]          band_select;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [BAND_SUM_W-1:0] band_sum;
    logic [FRAME_W-1:0]    band_samples;
    logic [BAND_W-1:0]     band_echo;
  } out_item_t;

  // One octave's filter state row
  typedef struct packed {
    logic signed [LP_W-1:0]  lp;
    logic signed [SLP_W-1:0] slp;
    logic                    parity;
  } filt_row_t;

endpackage

// ----- sv/obea_band_filter.sv -----
// ----------------------------------------------------------------------------
// obea_band_filter
// Octave lowpass update and sub-band split with magnitudes of both sub-bands.
// ----------------------------------------------------------------------------
module obea_band_filter
  import obea_pkg::*;
(
  input  logic signed [LP_W-1:0]  x_i,
  input  logic signed [LP_W-1:0]  lp_old_i,
  input  logic signed [LP_W-1:0]  lp_new_i,
  input  logic signed [SLP_W-1:0] slp_i,
  input  logic [SHIFT_W-1:0]      lowpass_shift_i,
  input  logic [SHIFT_W-1:0]      split_shift_i,
  output logic signed [LP_W-1:0]  lp_next_o,
  output logic signed [SLP_W-1:0] slp_next_o,
  output logic [MAG_W-1:0]        mag_hi_o,
  output logic [MAG_W-1:0]        mag_lo_o
);

  logic signed [LP_W:0]    diff1;
  logic signed [LP_W:0]    step1;
  logic signed [LP_W:0]    lp_sum;
  logic signed [LP_W:0]    hp;
  logic signed [MAG_W-1:0] hp_x;
  logic signed [MAG_W-1:0] slp_x;
  logic signed [MAG_W-1:0] diff2;
  logic signed [MAG_W-1:0] step2;
  logic signed [MAG_W-1:0] slp_sum;
  logic signed [MAG_W-1:0] sl_x;
  logic signed [MAG_W-1:0] sh;

  // Move the octave lowpass toward the input, wrap to its width
  assign diff1     = {x_i[LP_W-1], x_i} - {lp_old_i[LP_W-1], lp_old_i};
  assign step1     = diff1 >>> lowpass_shift_i;
  assign lp_sum    = {lp_old_i[LP_W-1], lp_old_i} + step1;
  assign lp_next_o = lp_sum[LP_W-1:0];

  // Highpass residual against the updated lowpass
  assign hp    = {x_i[LP_W-1], x_i} - {lp_new_i[LP_W-1], lp_new_i};
  assign hp_x  = {{(MAG_W-LP_W-1){hp[LP_W]}}, hp};
  assign slp_x = {{(MAG_W-SLP_W){slp_i[SLP_W-1]}}, slp_i};

  // Split lowpass update, wrap to its width
  assign diff2      = hp_x - slp_x;
  assign step2      = diff2 >>> split_shift_i;
  assign slp_sum    = slp_x + step2;
  assign slp_next_o = slp_sum[SLP_W-1:0];

  // Upper sub-band and magnitudes
  assign sl_x     = {{(MAG_W-SLP_W){slp_next_o[SLP_W-1]}}, slp_next_o};
  assign sh       = hp_x - sl_x;
  assign mag_hi_o = sh[MAG_W-1] ? MAG_W'(-sh) : MAG_W'(sh);
  assign mag_lo_o = sl_x[MAG_W-1] ? MAG_W'(-sl_x) : MAG_W'(sl_x);

endmodule

// ----- sv/octave_band_energy_analyzer_unit.sv -----
// ----------------------------------------------------------------------------
// octave_band_energy_analyzer_unit
// Octave cascade of lowpass and split filters with per-band magnitude sums.
// ----------------------------------------------------------------------------
// A sample item visits 1 to OCTAVES octaves (octave o is visited on one
// sample in 2^o). Each visit is a read of the octave's filter and sum rows,
// a lowpass step, a split step with filter write-back, and a saturating
// accumulate with sum write-back, all done by one shared filter unit over
// two memories. The filter memory is single-port; the sum memory has one
// read and one write port, since it writes back one octave's row in the
// same cycle as it reads the next one. A read item reads its row, then
// loads the result once the output register can take it. State is valid
// after reset at once: each memory row has a valid bit, so no clearing
// pass is run.
module octave_band_energy_analyzer_unit
  import obea_pkg::*;
#(
  parameter int OCTAVES   = DEF_OCTAVES,
  parameter int SUM_WIDTH = DEF_SUM_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  localparam int OCT_W = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
  localparam logic [OCT_W-1:0]       OCT_LAST = OCT_W'(OCTAVES - 1);
  localparam logic [OCT_LIMIT_W-1:0] OCT_LIM  = OCT_LIMIT_W'(OCTAVES);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOWPASS = 3'd1;
  localparam logic [2:0] ST_SPLIT   = 3'd2;
  localparam logic [2:0] ST_ACCUM   = 3'd3;
  localparam logic [2:0] ST_REPORT  = 3'd4;

  typedef logic [1:0][SUM_WIDTH-1:0] sum_row_t;

  logic [2:0]              state_q, state_d;
  logic [OCT_W-1:0]        oct_q, oct_d;
  logic signed [LP_W-1:0]  x_q, x_d;
  logic signed [LP_W-1:0]  lp_q;
  logic [MAG_W-1:0]        mag_hi_q, mag_lo_q;
  logic [BAND_W-1:0]       band_q;
  logic [FRAME_W-1:0]      frame_q;
  logic [SHIFT_W-1:0]      lp_shift_q, sp_shift_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  // Memories and their valid bits
  filt_row_t               filt_mem [OCTAVES];
  sum_row_t                sum_mem  [OCTAVES];
  logic [OCTAVES-1:0]      filt_vld_q, sum_vld_q;
  filt_row_t               filt_rd_q;
  sum_row_t                sum_rd_q;
  logic                    filt_rd_vld_q, sum_rd_vld_q;

  logic                    rd_en;
  logic [OCT_W-1:0]        rd_addr;
  logic                    filt_we, sum_we;
  filt_row_t               filt_wdata;
  sum_row_t                sum_wdata;
  filt_row_t               filt_cur;
  sum_row_t                sum_cur;

  logic                    in_acc;
  logic                    in_band_ok;
  logic signed [LP_W:0]    mono_sum;
  logic signed [LP_W-1:0]  lp_next, slp_next_unused_lp;
  logic signed [SLP_W-1:0] slp_next;
  logic [MAG_W-1:0]        mag_hi, mag_lo;
  logic                    go_on;
  logic                    out_load;
  logic [OCT_LIMIT_W-1:0]  rep_oct;
  logic [63:0]             rep_sum;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Stereo to mono
  assign mono_sum = {in_item_i.left_sample[SAMPLE_W-1], in_item_i.left_sample}
                  + {in_item_i.right_sample[SAMPLE_W-1], in_item_i.right_sample};

  assign in_band_ok = (OCT_LIMIT_W'(in_item_i.band_select[BAND_W-1:1]) < OCT_LIM);

  // Rows that were never written read as zero
  assign filt_cur = filt_rd_vld_q ? filt_rd_q : '0;
  assign sum_cur  = sum_rd_vld_q  ? sum_rd_q  : '0;

  // Shared filter unit: lowpass step in one state, split step in the next
  obea_band_filter u_filter (
    .x_i             (x_q),
    .lp_old_i        (filt_cur.lp),
    .lp_new_i        (lp_q),
    .slp_i           (filt_cur.slp),
    .lowpass_shift_i (lp_shift_q),
    .split_shift_i   (sp_shift_q),
    .lp_next_o       (lp_next),
    .slp_next_o      (slp_next),
    .mag_hi_o        (mag_hi),
    .mag_lo_o        (mag_lo)
  );

  assign slp_next_unused_lp = lp_next;

  // Continue down the cascade when the toggled parity comes back to zero
  assign go_on = filt_cur.parity && (oct_q != OCT_LAST);

  // Saturating accumulate of both sub-band magnitudes
  always_comb begin
    logic [SUM_WIDTH:0] ext_hi;
    logic [SUM_WIDTH:0] ext_lo;
    ext_hi = {1'b0, sum_cur[0]} + (SUM_WIDTH + 1)'(mag_hi_q);
    ext_lo = {1'b0, sum_cur[1]} + (SUM_WIDTH + 1)'(mag_lo_q);
    sum_wdata[0] = ext_hi[SUM_WIDTH] ? '1 : ext_hi[SUM_WIDTH-1:0];
    sum_wdata[1] = ext_lo[SUM_WIDTH] ? '1 : ext_lo[SUM_WIDTH-1:0];
  end

  assign filt_wdata.lp     = lp_q;
  assign filt_wdata.slp    = slp_next;
  assign filt_wdata.parity = ~filt_cur.parity;
  assign filt_we           = (state_q == ST_SPLIT);
  assign sum_we            = (state_q == ST_ACCUM);

  // Report path
  assign rep_oct  = OCT_LIMIT_W'(band_q[BAND_W-1:1]);
  assign rep_sum  = (rep_oct < OCT_LIM) ? 64'(sum_cur[band_q[0]]) : 64'd0;
  assign out_load = (state_q == ST_REPORT) && (!out_valid_q || out_ready_i);

  // Sequencer and memory read requests
  always_comb begin
    state_d = state_q;
    oct_d   = oct_q;
    x_d     = x_q;
    rd_en   = 1'b0;
    rd_addr = oct_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.func == FUNC_SAMPLE) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            oct_d   = '0;
            x_d     = mono_sum[LP_W:1];
            state_d = ST_LOWPASS;
          end else begin
            rd_en   = in_band_ok;
            rd_addr = OCT_W'(in_item_i.band_select[BAND_W-1:1]);
            state_d = ST_REPORT;
          end
        end
      end
      ST_LOWPASS: begin
        state_d = ST_SPLIT;
      end
      ST_SPLIT: begin
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (go_on) begin
          rd_en   = 1'b1;
          rd_addr = oct_q + OCT_W'(1);
          oct_d   = oct_q + OCT_W'(1);
          x_d     = lp_q;
          state_d = ST_LOWPASS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      oct_q         <= '0;
      frame_q       <= '0;
      lp_shift_q    <= LOWPASS_SHIFT_RST;
      sp_shift_q    <= SPLIT_SHIFT_RST;
      out_valid_q   <= 1'b0;
      filt_vld_q    <= '0;
      sum_vld_q     <= '0;
      filt_rd_vld_q <= 1'b0;
      sum_rd_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oct_q   <= oct_d;
      // Count sample items
      if (in_acc && (in_item_i.func == FUNC_SAMPLE)) begin
        frame_q <= frame_q + FRAME_W'(1);
      end
      // Take configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LOWPASS_SHIFT: lp_shift_q <= cfg_data_i[SHIFT_W-1:0];
          CFG_SPLIT_SHIFT:   sp_shift_q <= cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      // Hold or drop the result
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Mark rows written
      if (filt_we) begin
        filt_vld_q[oct_q] <= 1'b1;
      end
      if (sum_we) begin
        sum_vld_q[oct_q] <= 1'b1;
      end
      // Register row valid alongside read data
      if (rd_en) begin
        filt_rd_vld_q <= filt_vld_q[rd_addr];
        sum_rd_vld_q  <= sum_vld_q[rd_addr];
      end
    end
  end

  // Filter state memory
  always_ff @(posedge clk_i) begin
    if (filt_we) begin
      filt_mem[oct_q] <= filt_wdata;
    end
    if (rd_en) begin
      filt_rd_q <= filt_mem[rd_addr];
    end
  end

  // Band sum memory, one row per octave: upper band then lower band
  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[oct_q] <= sum_wdata;
    end
    if (rd_en) begin
      sum_rd_q <= sum_mem[rd_addr];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (state_q == ST_LOWPASS) begin
      lp_q <= slp_next_unused_lp;
    end
    if (state_q == ST_SPLIT) begin
      mag_hi_q <= mag_hi;
      mag_lo_q <= mag_lo;
    end
    if (in_acc) begin
      band_q <= in_item_i.band_select;
    end
    if (out_load) begin
      out_q.band_sum     <= rep_sum[BAND_SUM_W-1:0];
      out_q.band_samples <= frame_q >> band_q[BAND_W-1:1];
      out_q.band_echo    <= band_q;
    end
  end

endmodule

// ----- bench/tb_octave_band_energy_analyzer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_octave_band_energy_analyzer_unit
// Drives stereo sample items and band read items through the octave band
// energy analyzer. The bench keeps its own copy of the filter cascade and
// the band sums. Each band read item is checked against that copy or its
// directed row's typed answer. Sender and receiver both idle at random,
// and the shift settings are swept between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_octave_band_energy_analyzer_unit;
  import obea_pkg::*;

  localparam int OCTAVES      = DEF_OCTAVES;
  localparam int SUM_W        = BAND_SUM_W;
  // Drain time before config, with margin over the longest sample item
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 230;
  localparam int DIR_N        = 23;

  // One directed row: input item, whether the answer is typed in, the answer
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Mirror of the block's state
  logic [SHIFT_W-1:0] lp_shift_q    = LOWPASS_SHIFT_RST;
  logic [SHIFT_W-1:0] split_shift_q = SPLIT_SHIFT_RST;
  int                 oct_lp     [OCTAVES];
  int                 split_lp   [OCTAVES];
  logic               oct_parity [OCTAVES];
  logic [SUM_W-1:0]   energy_sums [2*OCTAVES];
  logic [FRAME_W-1:0] frames_seen = '0;

  out_item_t want_reads [$];
  int        errors     = 0;
  bit        tx_steady  = 1'b0;
  logic      rx_steady  = 1'b0;
  int        rx_hold    = 0;

  // Columns: func, left, right, band | typed | band_sum, band_samples, echo
  dir_row_t dir_table [0:DIR_N-1] = '{
    {FUNC_READ,   16'h7FFF, 16'h8000, 4'd0,  1'b1, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'hFFFF, 16'hFFFF, 4'd15, 1'b1, 48'd0, 32'd0, 4'd15},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd7,  1'b1, 48'd0, 32'd0, 4'd7},
    {FUNC_SAMPLE, 16'h7FFF, 16'h7FFF, 4'd15, 1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h8000, 16'h8000, 4'd0,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h7FFF, 16'h8000, 4'd3,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h8000, 16'h7FFF, 4'd9,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'hFFFF, 16'h0000, 4'd0,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h0001, 16'h0000, 4'd0,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h0000, 16'h0000, 4'd10, 1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h5555, 16'hAAAA, 4'd5,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h1234, 16'hEDCB, 4'd12, 1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd0,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd1,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'hAAAA, 16'h5555, 4'd2,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd3,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd6,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd14, 1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd15, 1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h7FFF, 16'h7FFF, 4'd0,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_SAMPLE, 16'h8000, 16'h8000, 4'd0,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd0,  1'b0, 48'd0, 32'd0, 4'd0},
    {FUNC_READ,   16'h0000, 16'h0000, 4'd1,  1'b0, 48'd0, 32'd0, 4'd0}
  };

  octave_band_energy_analyzer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Keep the low w bits of v as a signed value
  function automatic int wrap_to(input int v, input int w);
    return (v <<< (32 - w)) >>> (32 - w);
  endfunction

  // Add a magnitude into one band sum, saturating at all ones
  function automatic void add_magnitude(input int band, input int v);
    logic [31:0]  m;
    logic [SUM_W:0] t;
    m = (v < 0) ? -v : v;
    t = {1'b0, energy_sums[band]} + m;
    if (t > {1'b0, {SUM_W{1'b1}}}) energy_sums[band] = {SUM_W{1'b1}};
    else energy_sums[band] = t[SUM_W-1:0];
  endfunction

  // Advance the octave cascade by one stereo sample item
  function automatic void run_cascade(input logic signed [SAMPLE_W-1:0] l,
                                      input logic signed [SAMPLE_W-1:0] r);
    int x, lp, hp, sl, o;
    x = (int'(l) + int'(r)) >>> 1;
    for (o = 0; o < OCTAVES; o++) begin
      lp = wrap_to(oct_lp[o] + ((x - oct_lp[o]) >>> lp_shift_q), LP_W);
      oct_lp[o] = lp;
      hp = x - lp;
      sl = wrap_to(split_lp[o] + ((hp - split_lp[o]) >>> split_shift_q), SLP_W);
      split_lp[o] = sl;
      add_magnitude(2 * o, hp - sl);
      add_magnitude(2 * o + 1, sl);
      oct_parity[o] = !oct_parity[o];
      if (oct_parity[o]) break;
      x = lp;
    end
    frames_seen = frames_seen + 1'b1;
  endfunction

  // Answer expected for a band read item
  function automatic out_item_t band_report(input logic [BAND_W-1:0] band);
    out_item_t r;
    r.band_sum     = (band < 2 * OCTAVES) ? energy_sums[band] : '0;
    r.band_samples = frames_seen >> (band >> 1);
    r.band_echo    = band;
    return r;
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rail_value();
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then update the mirror
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.func == FUNC_READ) want_reads.push_back(typed ? want : band_report(it.band_select));
    else run_cascade(it.left_sample, it.right_sample);
  endtask

  // Hold off until every read is answered and the last sample has drained
  task automatic settle();
    in_valid_i <= 1'b0;
    while (want_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both shift registers while the block is idle
  task automatic set_shifts(input logic [SHIFT_W-1:0] lp_s, input logic [SHIFT_W-1:0] sp_s);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOWPASS_SHIFT;
    cfg_data_i <= lp_s;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPLIT_SHIFT;
    cfg_data_i <= sp_s;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lp_shift_q    = lp_s;
    split_shift_q = sp_s;
  endtask

  // Drop ready for random stretches
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold     <= idle_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each band result against the oldest pending read
  always @(posedge clk_i) begin : check_results
    out_item_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (want_reads.size() == 0) begin
        $error("band result with no read pending: echo %0d", out_item_o.band_echo);
        errors++;
      end else begin
        head = want_reads.pop_front();
        if (out_item_o.band_sum !== head.band_sum) begin
          $error("band_sum: expected %0h, got %0h", head.band_sum, out_item_o.band_sum);
          errors++;
        end
        if (out_item_o.band_samples !== head.band_samples) begin
          $error("band_samples: expected %0h, got %0h",
                 head.band_samples, out_item_o.band_samples);
          errors++;
        end
        if (out_item_o.band_echo !== head.band_echo) begin
          $error("band_echo: expected %0d, got %0d", head.band_echo, out_item_o.band_echo);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t none;
    int        ph, n;
    none = '0;
    foreach (oct_lp[i]) begin
      oct_lp[i]     = 0;
      split_lp[i]   = 0;
      oct_parity[i] = 1'b0;
    end
    foreach (energy_sums[i]) energy_sums[i] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset shift settings
    foreach (dir_table[i]) push_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);

    // Random phases, one shift setting each
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_shifts(4'd0, 4'd0);
        1: set_shifts(4'd15, 4'd15);
        2: set_shifts(4'd0, 4'd15);
        3: set_shifts(4'd15, 4'd0);
        default: set_shifts(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) begin
          tx_steady  = ($urandom_range(0, 3) == 0);
          rx_steady <= ($urandom_range(0, 3) == 0);
        end
        // Now and then let every pending read come back first
        if ($urandom_range(0, 59) == 0) settle();
        it.band_select  = 4'($urandom_range(0, 15));
        it.left_sample  = 16'($urandom);
        it.right_sample = 16'($urandom);
        if ($urandom_range(0, 99) < 22) begin
          it.func = FUNC_READ;
        end else begin
          it.func = FUNC_SAMPLE;
          case ($urandom_range(0, 9))
            0: begin
              it.left_sample  = rail_value();
              it.right_sample = rail_value();
            end
            1, 2: begin
              it.left_sample  = 16'(int'($urandom_range(0, 255)) - 128);
              it.right_sample = 16'(int'($urandom_range(0, 255)) - 128);
            end
            default: ;
          endcase
        end
        push_item(it, 1'b0, none);
      end
    end

    settle();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
sv/obea_pkg.sv
sv/obea_band_filter.sv
sv/octave_band_energy_analyzer_unit.sv
bench/tb_octave_band_energy_analyzer_unit.sv
